@@ rtl/sfr_pkg.sv @@
// Shared types and constants for the serial frame receiver.
// No dependencies; imported by sfr_core and the top level.
package sfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 17;
  localparam int EVENT_W = 3;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHONE_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_ADDRESS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYPE      = 2'd3;

  // Register reset values.
  localparam logic [BYTE_W-1:0] SYNC_BYTE_RST     = 8'd31;
  localparam logic [BYTE_W-1:0] PHONE_ADDRESS_RST = 8'd0;
  localparam logic [BYTE_W-1:0] HOST_ADDRESS_RST  = 8'd29;
  localparam logic [BYTE_W-1:0] ACK_TYPE_RST      = 8'd127;

  typedef enum logic [EVENT_W-1:0] {
    EV_HEADER  = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_GOOD    = 3'd2,
    EV_BADSUM  = 3'd3,
    EV_ACK     = 3'd4,
    EV_SYNCERR = 3'd5,
    EV_ADDRERR = 3'd6,
    EV_IGNORED = 3'd7
  } event_t;

  typedef enum logic [6:0] {
    PH_SYNC   = 7'b0000001,
    PH_DEST   = 7'b0000010,
    PH_SRC    = 7'b0000100,
    PH_TYPE   = 7'b0001000,
    PH_LEN_HI = 7'b0010000,
    PH_LEN_LO = 7'b0100000,
    PH_BODY   = 7'b1000000
  } phase_t;

  typedef struct packed {
    event_t             event_res;
    logic [BYTE_W-1:0]  payload_byte;
    logic [LEN_W-1:0]   payload_index;
    logic [BYTE_W-1:0]  frame_type;
    logic [LEN_W-1:0]   frame_length;
    logic [BYTE_W-1:0]  frame_source;
    logic [BYTE_W-1:0]  frame_sequence;
  } result_t;

endpackage

@@ rtl/sfr_core.sv @@
// Deframing state machine: configuration registers, frame state and the
// per-byte step logic. Depends on sfr_pkg.
module sfr_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::BYTE_W-1:0]       cfg_data,
  input  logic                             step,
  input  logic [sfr_pkg::BYTE_W-1:0]       rx_byte,
  output sfr_pkg::result_t                 res
);
  import sfr_pkg::*;

  logic [BYTE_W-1:0] sync_byte_r, phone_addr_r, host_addr_r, ack_type_r;

  phase_t                 phase_r, phase_nxt;
  logic [BYTE_W-1:0]      xor_r, xor_nxt;
  logic [BYTE_W-1:0]      dest_r, dest_nxt;
  logic [BYTE_W-1:0]      source_r, source_nxt;
  logic [BYTE_W-1:0]      type_r, type_nxt;
  logic [BYTE_W-1:0]      seq_r, seq_nxt;
  logic [LENGTH_BITS-1:0] length_r, length_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;

  logic              known_addr;
  logic [LEN_W-1:0]  len_hi_word;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  length_ext;
  logic [CNT_W-1:0]  pidx_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r  <= SYNC_BYTE_RST;
      phone_addr_r <= PHONE_ADDRESS_RST;
      host_addr_r  <= HOST_ADDRESS_RST;
      ack_type_r   <= ACK_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_BYTE:     sync_byte_r  <= cfg_data;
        CFG_PHONE_ADDRESS: phone_addr_r <= cfg_data;
        CFG_HOST_ADDRESS:  host_addr_r  <= cfg_data;
        CFG_ACK_TYPE:      ack_type_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC;
      xor_r    <= '0;
      dest_r   <= '0;
      source_r <= '0;
      type_r   <= '0;
      seq_r    <= '0;
      length_r <= '0;
      count_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      xor_r    <= xor_nxt;
      dest_r   <= dest_nxt;
      source_r <= source_nxt;
      type_r   <= type_nxt;
      seq_r    <= seq_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
    end
  end

  assign known_addr  = (rx_byte == phone_addr_r) || (rx_byte == host_addr_r);
  assign len_hi_word = {rx_byte, 8'h00};
  assign count_inc   = count_r + CNT_W'(1);
  assign length_ext  = CNT_W'(length_r);
  assign pidx_wide   = count_inc - CNT_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    xor_nxt    = xor_r ^ rx_byte;
    dest_nxt   = dest_r;
    source_nxt = source_r;
    type_nxt   = type_r;
    seq_nxt    = seq_r;
    length_nxt = length_r;
    count_nxt  = count_r;

    res.event_res      = EV_HEADER;
    res.payload_byte   = '0;
    res.payload_index  = '0;
    res.frame_sequence = '0;

    case (phase_r)
      PH_DEST: begin
        if (known_addr) begin
          dest_nxt  = rx_byte;
          phase_nxt = PH_SRC;
        end else begin
          res.event_res = EV_ADDRERR;
          phase_nxt     = PH_SYNC;
        end
      end
      PH_SRC: begin
        if (known_addr) begin
          source_nxt = rx_byte;
          phase_nxt  = PH_TYPE;
        end else begin
          res.event_res = EV_ADDRERR;
          phase_nxt     = PH_SYNC;
        end
      end
      PH_TYPE: begin
        type_nxt  = rx_byte;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_nxt = len_hi_word[LENGTH_BITS-1:0];
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (type_r == ack_type_r) begin
          res.event_res = EV_ACK;
          phase_nxt     = PH_SYNC;
        end else begin
          length_nxt = LENGTH_BITS'(length_r + LENGTH_BITS'(rx_byte));
          phase_nxt  = PH_BODY;
        end
      end
      PH_BODY: begin
        count_nxt = count_inc;
        if (count_inc <= length_ext) begin
          res.event_res     = EV_PAYLOAD;
          res.payload_byte  = rx_byte;
          res.payload_index = pidx_wide[LEN_W-1:0];
        end else if (count_inc == length_ext + CNT_W'(1)) begin
          seq_nxt = rx_byte;
        end else begin
          // The checksum byte must equal the XOR of every earlier byte.
          if (xor_r == rx_byte) begin
            if (dest_r != phone_addr_r) begin
              res.event_res      = EV_GOOD;
              res.frame_sequence = seq_r;
            end else begin
              res.event_res = EV_IGNORED;
            end
          end else begin
            res.event_res = EV_BADSUM;
          end
          phase_nxt = PH_SYNC;
        end
      end
      default: begin
        // Waiting for the sync byte; any unused phase code lands here too.
        phase_nxt = PH_SYNC;
        if (rx_byte == sync_byte_r) begin
          xor_nxt   = sync_byte_r;
          count_nxt = '0;
          phase_nxt = PH_DEST;
        end else begin
          res.event_res = EV_SYNCERR;
        end
      end
    endcase

    res.frame_type   = type_nxt;
    res.frame_length = LEN_W'(length_nxt);
    res.frame_source = source_nxt;
  end

endmodule

@@ rtl/serial_frame_receiver_xor_checksum.sv @@
// Top level of the serial frame receiver: input register, output register
// and valid/stall handshake around sfr_core. Depends on sfr_pkg, sfr_core.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in_     | input     | in_valid/in_stall  | in_rx_data
//   out_    | output    | out_valid/out_stall| event, payload byte/index, frame
//   cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low; each byte is held in the
// input register, and its result is then stored in the result register.
// The frame state advances only when the input register moves into the
// result register, so stalls on the output side freeze the parser in place.
// Reset is synchronous and active low; it clears the phase, checksum and
// counters and loads the register defaults. No clearing pass is needed.
// in_stall rises only when both registers hold data and out_stall is high.
module serial_frame_receiver_xor_checksum #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_rx_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sfr_pkg::EVENT_W-1:0]     out_event_res,
  output logic [sfr_pkg::BYTE_W-1:0]      out_payload_byte,
  output logic [sfr_pkg::LEN_W-1:0]       out_payload_index,
  output logic [sfr_pkg::BYTE_W-1:0]      out_frame_type,
  output logic [sfr_pkg::LEN_W-1:0]       out_frame_length,
  output logic [sfr_pkg::BYTE_W-1:0]      out_frame_source,
  output logic [sfr_pkg::BYTE_W-1:0]      out_frame_sequence
);
  import sfr_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;
  result_t           core_res;

  logic advance;   // the result register can take a new value this cycle
  logic s1_fire;   // the buffered byte is processed and its result stored
  logic in_xfer;   // an input transfer completes this cycle

  assign advance  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_rx_data;
    end
    if (s1_fire) begin
      out_res_r <= core_res;
    end
  end

  sfr_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (s1_fire),
    .rx_byte  (s1_byte_r),
    .res      (core_res)
  );

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_res_r.event_res;
  assign out_payload_byte   = out_res_r.payload_byte;
  assign out_payload_index  = out_res_r.payload_index;
  assign out_frame_type     = out_res_r.frame_type;
  assign out_frame_length   = out_res_r.frame_length;
  assign out_frame_source   = out_res_r.frame_source;
  assign out_frame_sequence = out_res_r.frame_sequence;

  // The input side only holds off while a byte is buffered behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall without a blocked result");

  // A new result only appears after a buffered byte was processed.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a buffered byte");

  // Payload fields are zero for every event but a payload byte.
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.event_res != EV_PAYLOAD))
      |-> (out_res_r.payload_byte == '0 && out_res_r.payload_index == '0))
    else $error("payload fields set on a non-payload event");

  // The sequence number is reported only with a good frame.
  a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.event_res != EV_GOOD))
      |-> (out_res_r.frame_sequence == '0))
    else $error("sequence reported outside a good frame");

endmodule
